@@ sv/ffsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_pkg
// Shared widths, constants and types of the fuzzy following speed controller.
// ----------------------------------------------------------------------------
package ffsc_pkg;

	// field widths
	localparam int SpeedW = 9;
	localparam int GapW   = 10;
	localparam int OffW   = 4;
	localparam int AccW   = 15;

	// label counts
	localparam int NumInLabels  = 5;
	localparam int NumOutLabels = 9;
	localparam int LabW         = 3;
	localparam int OutLabW      = 4;

	// membership weights, unsigned Q1.15
	localparam int WeightW  = 16;
	localparam int WOne     = 32768;
	localparam int SpeedDiv = 45;
	localparam int GapDiv   = 20;

	// sums handed from front to back
	localparam int WsumW = 21;
	localparam int DenW  = 20;

	// divider
	localparam int QuoW = 14;
	localparam int MagW = WsumW - 1;
	localparam int NumW = 31;
	localparam int RemW = DenW + QuoW;

	// queue
	localparam int QueueDepth = 4;

	// configuration port
	localparam int AddrW = 3;
	localparam int DataW = 32;
	localparam logic [0:0]      RegGapOffset   = 1'b0;
	localparam logic [OffW-1:0] GapOffsetReset = 4'd2;

	typedef logic [WeightW-1:0] weight_t;

	// one queue entry: weighted label sum and total strength
	typedef struct packed {
		logic signed [WsumW-1:0] wsum;
		logic [DenW-1:0]         den;
	} ffsc_sums_t;

endpackage
`default_nettype wire

@@ sv/ffsc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_front
// Input stage: fuzzifies speed and gap, fires the rules and forms the sums.
// ----------------------------------------------------------------------------
module ffsc_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [ffsc_pkg::SpeedW-1:0]     speed,
	input  wire logic signed [ffsc_pkg::GapW-1:0]       gap,
	input  wire logic [ffsc_pkg::OffW-1:0]              gap_offset,
	input  wire logic                                   q_full,
	output logic                                        push,
	output ffsc_pkg::ffsc_sums_t                        push_data
);

	typedef ffsc_pkg::weight_t w45_tab_t [0:63];
	typedef ffsc_pkg::weight_t w20_tab_t [0:31];

	function automatic w45_tab_t build_w45();
		w45_tab_t t;
		for (int d = 0; d < 64; d++) begin
			t[d] = (d < ffsc_pkg::SpeedDiv) ?
				ffsc_pkg::WeightW'((d * ffsc_pkg::WOne) / ffsc_pkg::SpeedDiv) : '0;
		end
		return t;
	endfunction

	function automatic w20_tab_t build_w20();
		w20_tab_t t;
		for (int d = 0; d < 32; d++) begin
			t[d] = (d < ffsc_pkg::GapDiv) ?
				ffsc_pkg::WeightW'((d * ffsc_pkg::WOne) / ffsc_pkg::GapDiv) : '0;
		end
		return t;
	endfunction

	localparam w45_tab_t W45 = build_w45();
	localparam w20_tab_t W20 = build_w20();
	localparam int SpeedPts [ffsc_pkg::NumInLabels] = '{-5, 40, 85, 125, 165};
	localparam int GapPts   [ffsc_pkg::NumInLabels] = '{0, 20, 40, 60, 80};

	logic                                 en;
	logic                                 vld_s1, vld_s2;
	logic signed [ffsc_pkg::SpeedW-1:0]   speed_s1;
	logic signed [ffsc_pkg::GapW-1:0]     gap_s1;
	ffsc_pkg::weight_t                    str_s2 [ffsc_pkg::NumOutLabels];

	logic signed [ffsc_pkg::GapW:0]       g_adj;
	logic [ffsc_pkg::LabW-1:0]            s_hi_lab, s_lo_lab, g_hi_lab, g_lo_lab;
	ffsc_pkg::weight_t                    s_hi_w, s_lo_w, g_hi_w, g_lo_w;
	logic signed [ffsc_pkg::GapW:0]       s_a, s_b, g_a, g_b;
	logic                                 s_seg, g_seg;
	logic signed [ffsc_pkg::GapW:0]       s_dhi, s_dlo, g_dhi, g_dlo;
	logic [ffsc_pkg::LabW-1:0]            p_slab [4];
	logic [ffsc_pkg::LabW-1:0]            p_glab [4];
	ffsc_pkg::weight_t                    p_sw [4];
	ffsc_pkg::weight_t                    p_gw [4];
	ffsc_pkg::weight_t                    p_min;
	logic [ffsc_pkg::OutLabW-1:0]         p_out;
	ffsc_pkg::weight_t                    str [ffsc_pkg::NumOutLabels];
	logic signed [ffsc_pkg::WsumW-1:0]    wsum;
	logic [ffsc_pkg::DenW-1:0]            den;

	// front advances as long as the queue has room
	assign en       = !q_full;
	assign in_stall = !en;
	assign push     = vld_s2 && en;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (en) begin
			speed_s1 <= speed;
			gap_s1   <= gap;
		end
	end

	// gap less offset at full width
	assign g_adj = {gap_s1[ffsc_pkg::GapW-1], gap_s1} - {7'b0, gap_offset};

	// speed fuzzification: locate segment, then one table read per label
	always_comb begin
		s_hi_lab = '0;
		s_lo_lab = '0;
		s_seg    = 1'b0;
		s_a      = '0;
		s_b      = '0;
		if (speed_s1 > SpeedPts[ffsc_pkg::NumInLabels-1]) begin
			s_hi_lab = ffsc_pkg::LabW'(ffsc_pkg::NumInLabels - 1);
		end
		for (int i = 1; i < ffsc_pkg::NumInLabels; i++) begin
			if (speed_s1 == SpeedPts[i]) begin
				s_hi_lab = ffsc_pkg::LabW'(i);
			end else if (speed_s1 > SpeedPts[i-1] && speed_s1 < SpeedPts[i]) begin
				s_hi_lab = ffsc_pkg::LabW'(i);
				s_lo_lab = ffsc_pkg::LabW'(i - 1);
				s_seg    = 1'b1;
				s_a      = (ffsc_pkg::GapW+1)'(SpeedPts[i-1]);
				s_b      = (ffsc_pkg::GapW+1)'(SpeedPts[i]);
			end
		end
		s_dhi  = {{2{speed_s1[ffsc_pkg::SpeedW-1]}}, speed_s1} - s_a;
		s_dlo  = s_b - {{2{speed_s1[ffsc_pkg::SpeedW-1]}}, speed_s1};
		s_hi_w = s_seg ? W45[s_dhi[5:0]] : ffsc_pkg::WeightW'(ffsc_pkg::WOne);
		s_lo_w = s_seg ? W45[s_dlo[5:0]] : '0;
	end

	// gap fuzzification
	always_comb begin
		g_hi_lab = '0;
		g_lo_lab = '0;
		g_seg    = 1'b0;
		g_a      = '0;
		g_b      = '0;
		if (g_adj > GapPts[ffsc_pkg::NumInLabels-1]) begin
			g_hi_lab = ffsc_pkg::LabW'(ffsc_pkg::NumInLabels - 1);
		end
		for (int i = 1; i < ffsc_pkg::NumInLabels; i++) begin
			if (g_adj == GapPts[i]) begin
				g_hi_lab = ffsc_pkg::LabW'(i);
			end else if (g_adj > GapPts[i-1] && g_adj < GapPts[i]) begin
				g_hi_lab = ffsc_pkg::LabW'(i);
				g_lo_lab = ffsc_pkg::LabW'(i - 1);
				g_seg    = 1'b1;
				g_a      = (ffsc_pkg::GapW+1)'(GapPts[i-1]);
				g_b      = (ffsc_pkg::GapW+1)'(GapPts[i]);
			end
		end
		g_dhi  = g_adj - g_a;
		g_dlo  = g_b - g_adj;
		g_hi_w = g_seg ? W20[g_dhi[4:0]] : ffsc_pkg::WeightW'(ffsc_pkg::WOne);
		g_lo_w = g_seg ? W20[g_dlo[4:0]] : '0;
	end

	// four rules, min strength, max per output label
	always_comb begin
		p_slab[0] = s_hi_lab; p_sw[0] = s_hi_w; p_glab[0] = g_hi_lab; p_gw[0] = g_hi_w;
		p_slab[1] = s_hi_lab; p_sw[1] = s_hi_w; p_glab[1] = g_lo_lab; p_gw[1] = g_lo_w;
		p_slab[2] = s_lo_lab; p_sw[2] = s_lo_w; p_glab[2] = g_hi_lab; p_gw[2] = g_hi_w;
		p_slab[3] = s_lo_lab; p_sw[3] = s_lo_w; p_glab[3] = g_lo_lab; p_gw[3] = g_lo_w;
		for (int k = 0; k < ffsc_pkg::NumOutLabels; k++) begin
			str[k] = '0;
		end
		p_min = '0;
		p_out = '0;
		for (int p = 0; p < 4; p++) begin
			p_min = (p_sw[p] < p_gw[p]) ? p_sw[p] : p_gw[p];
			p_out = ffsc_pkg::OutLabW'(4) + {1'b0, p_glab[p]} - {1'b0, p_slab[p]};
			if (p_min > str[p_out]) begin
				str[p_out] = p_min;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ffsc_pkg::NumOutLabels; k++) begin
				str_s2[k] <= str[k];
			end
		end
	end

	// weighted label sum (weight = label - 4, the centre over 10) and total strength
	always_comb begin
		wsum = '0;
		den  = '0;
		for (int k = 0; k < ffsc_pkg::NumOutLabels; k++) begin
			wsum = wsum + $signed({5'b0, str_s2[k]}) * ffsc_pkg::WsumW'(k - 4);
			den  = den + {4'b0, str_s2[k]};
		end
	end

	assign push_data.wsum = wsum;
	assign push_data.den  = den;

endmodule
`default_nettype wire

@@ sv/ffsc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_queue
// Short register queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module ffsc_queue #(
	parameter int DEPTH = ffsc_pkg::QueueDepth
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ffsc_pkg::ffsc_sums_t push_data,
	input  wire logic                 pop,
	output ffsc_pkg::ffsc_sums_t      pop_data,
	output logic                      full,
	output logic                      empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	ffsc_pkg::ffsc_sums_t mem_q [DEPTH];
	logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]      count_q;

	assign full     = (count_q == CntW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ sv/ffsc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_back
// Back end: pipelined restoring divider, one quotient bit per stage, and the
// output register.
// ----------------------------------------------------------------------------
module ffsc_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  wire ffsc_pkg::ffsc_sums_t                q_data,
	output logic                                     pop,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [ffsc_pkg::AccW-1:0]         accel,
	output logic                                     braking
);

	localparam int NS = ffsc_pkg::QuoW;

	logic                            en;
	logic [NS:0]                     vld_q;
	logic [ffsc_pkg::RemW-1:0]       rem_q [NS+1];
	logic [ffsc_pkg::DenW-1:0]       den_q [NS+1];
	logic                            neg_q [NS+1];
	logic [ffsc_pkg::QuoW-1:0]       quo_q [NS+1];
	logic [ffsc_pkg::RemW-1:0]       nrem  [NS+1];
	logic [ffsc_pkg::QuoW-1:0]       nquo  [NS+1];
	logic                            out_vld_q;
	logic signed [ffsc_pkg::AccW-1:0] accel_q;
	logic                            braking_q;

	logic                            ld_neg;
	logic [ffsc_pkg::MagW-1:0]       ld_mag;
	logic [ffsc_pkg::NumW-1:0]       ld_num;
	logic [ffsc_pkg::WsumW-1:0]      ld_abs;
	logic [ffsc_pkg::AccW-1:0]       q_ext;

	// whole back end holds while a result waits
	assign en        = !(out_vld_q && out_stall);
	assign pop       = en && !q_empty;
	assign out_valid = out_vld_q;
	assign accel     = accel_q;
	assign braking   = braking_q;

	// load: magnitude of numerator scaled by 2560 (centre step 10, Q7.8)
	assign ld_neg = q_data.wsum[ffsc_pkg::WsumW-1];
	assign ld_abs = ld_neg ? -q_data.wsum : q_data.wsum;
	assign ld_mag = ld_abs[ffsc_pkg::MagW-1:0];
	assign ld_num = {ld_mag, 11'b0} + {2'b0, ld_mag, 9'b0};

	// one compare and subtract per stage
	always_comb begin
		nrem[0] = '0;
		nquo[0] = '0;
		for (int j = 1; j <= NS; j++) begin
			if (rem_q[j-1] >= ({{ffsc_pkg::QuoW{1'b0}}, den_q[j-1]} << (NS - j))) begin
				nrem[j] = rem_q[j-1] - ({{ffsc_pkg::QuoW{1'b0}}, den_q[j-1]} << (NS - j));
				nquo[j] = quo_q[j-1] | (ffsc_pkg::QuoW'(1) << (NS - j));
			end else begin
				nrem[j] = rem_q[j-1];
				nquo[j] = quo_q[j-1];
			end
		end
	end

	// stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[NS-1:0], pop};
			out_vld_q <= vld_q[NS];
		end
	end

	// divider payload
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= {3'b0, ld_num};
			den_q[0] <= q_data.den;
			neg_q[0] <= ld_neg;
			quo_q[0] <= '0;
			for (int j = 1; j <= NS; j++) begin
				rem_q[j] <= nrem[j];
				den_q[j] <= den_q[j-1];
				neg_q[j] <= neg_q[j-1];
				quo_q[j] <= nquo[j];
			end
		end
	end

	// sign restore, truncation toward zero
	assign q_ext = {1'b0, quo_q[NS]};

	always_ff @(posedge clk) begin
		if (en) begin
			accel_q   <= neg_q[NS] ? -$signed(q_ext) : $signed(q_ext);
			braking_q <= neg_q[NS] && (quo_q[NS] != '0);
		end
	end

endmodule
`default_nettype wire

@@ sv/fuzzy_following_speed_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_following_speed_controller
// Fuzzy car-following controller: speed and gap in, acceleration out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_stall, speed, gap): one transaction per sample.
//   Output channel (out_valid/out_stall, accel, braking): one transaction per
//   input transaction, in order. accel is signed Q7.8 in -40..40, braking
//   marks a negative accel.
//   Register gap_offset sits at byte address 0 of the APB port; pready is
//   always high. Write it only while no transaction is in flight.
// Timing
//   One transaction per cycle sustained while out_stall is low. From input
//   acceptance to output valid it passes two front stages, the queue, the load
//   stage, 14 divider stages (one quotient bit each) and the output register.
// Reset
//   arst_n clears all valids and the queue, and sets gap_offset to 2.
// Stall
//   A stalled result holds the whole divider pipeline; the front keeps
//   accepting until the 4-entry queue fills, then raises in_stall.
// ----------------------------------------------------------------------------
module fuzzy_following_speed_controller #(
	parameter int QUEUE_DEPTH = ffsc_pkg::QueueDepth
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [ffsc_pkg::AddrW-1:0]           paddr,
	input  wire logic [ffsc_pkg::DataW-1:0]           pwdata,
	output logic [ffsc_pkg::DataW-1:0]                prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [ffsc_pkg::SpeedW-1:0]   speed,
	input  wire logic signed [ffsc_pkg::GapW-1:0]     gap,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [ffsc_pkg::AccW-1:0]          accel,
	output logic                                      braking
);

	logic [ffsc_pkg::OffW-1:0] gap_offset_q;
	logic                      reg_wr;
	logic [0:0]                reg_idx;
	logic                      push, pop, q_full, q_empty;
	ffsc_pkg::ffsc_sums_t      push_data, pop_data;

	// configuration register
	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_offset_q <= ffsc_pkg::GapOffsetReset;
		end else if (reg_wr && reg_idx == ffsc_pkg::RegGapOffset) begin
			gap_offset_q <= pwdata[ffsc_pkg::OffW-1:0];
		end
	end

	assign prdata = (reg_idx == ffsc_pkg::RegGapOffset) ?
		{{(ffsc_pkg::DataW - ffsc_pkg::OffW){1'b0}}, gap_offset_q} : '0;

	ffsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.speed      (speed),
		.gap        (gap),
		.gap_offset (gap_offset_q),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	ffsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	ffsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accel     (accel),
		.braking   (braking)
	);

endmodule
`default_nettype wire

@@ sv/ffsc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_checker
// Port-level checks on the controller's output channel.
// ----------------------------------------------------------------------------
module ffsc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [ffsc_pkg::AccW-1:0]  accel,
	input wire logic                              braking
);

	// stalled result stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped under stall");

	// stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(accel) && $stable(braking))
		else $error("output changed under stall");

	// braking flag follows the sign of accel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (braking == accel[ffsc_pkg::AccW-1]))
		else $error("braking does not match accel sign");

	// accel stays within the outer singleton centres
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accel >= -15'sd10240) && (accel <= 15'sd10240))
		else $error("accel out of range");

endmodule

bind fuzzy_following_speed_controller ffsc_checker u_ffsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.accel     (accel),
	.braking   (braking)
);
`default_nettype wire
